// ===== sv/mfc_pkg.sv =====
// Shared types and constants for the multichannel frequency counter.
// Used by mfc_div and multichannel_frequency_counter; depends on nothing.
`default_nettype none
package mfc_pkg;
	localparam int IN_PORT_W = 16;
	localparam int CH_IN_W   = 5;
	localparam int TIME_W    = 48;
	localparam int CNT_W     = 32;
	localparam int SCALE_W   = 30;
	localparam int NUM_W     = CNT_W + SCALE_W;
	localparam int Q_W       = 32;

	// Microseconds per second times millihertz per hertz.
	localparam logic [SCALE_W-1:0] SCALE = 30'd1_000_000_000;

	typedef enum logic [1:0] {
		CMD_PORT  = 2'd0,
		CMD_EDGE  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;
endpackage
`default_nettype wire

// ===== sv/mfc_div.sv =====
// Iterative restoring divider: edge count product over elapsed microseconds.
// One quotient bit per cycle with saturation and zero-divisor detection; uses mfc_pkg.
`default_nettype none
module mfc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [mfc_pkg::NUM_W-1:0]  num,
	input  logic [mfc_pkg::TIME_W-1:0] den,
	output logic                    done,
	output logic [mfc_pkg::Q_W-1:0] quot,
	output mfc_pkg::status_t        status
);
	import mfc_pkg::*;

	localparam int CW = $clog2(Q_W + 1);
	localparam logic [CW-1:0] ITERS = CW'(Q_W);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [TIME_W-1:0]   rem_q;
	logic [TIME_W-1:0]   den_q;
	logic [Q_W-1:0]      lo_q;
	logic [Q_W-1:0]      quot_q;
	status_t             status_q;
	logic [TIME_W+1:0]   diff;
	logic                ge;
	logic                sat;

	// The quotient fits in Q_W bits exactly when the upper numerator part is below the divisor.
	assign sat  = (TIME_W'(num[NUM_W-1:Q_W]) >= den);
	assign diff = {1'b0, rem_q, lo_q[Q_W-1]} - {2'b00, den_q};
	assign ge   = ~diff[TIME_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= TIME_W'(num[NUM_W-1:Q_W]);
			lo_q  <= num[Q_W-1:0];
			cnt_q <= ITERS;
			if (den == '0) begin
				quot_q   <= '0;
				status_q <= ST_ZERO;
			end else if (sat) begin
				quot_q   <= '1;
				status_q <= ST_SAT;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : {rem_q[TIME_W-2:0], lo_q[Q_W-1]};
			lo_q  <= {lo_q[Q_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				quot_q   <= {lo_q[Q_W-2:0], ge};
				status_q <= ST_OK;
			end
		end
	end

	assign done   = done_q;
	assign quot   = quot_q;
	assign status = status_q;
endmodule
`default_nettype wire

// ===== sv/multichannel_frequency_counter.sv =====
// Multichannel frequency counter: per-channel edge counts and last read or clear times in two
// synchronous memories, read-modify-write under a one-hot sequencer, readout divider.
// Commands are taken one at a time, only in idle: a clear is written on acceptance, an edge
// makes one count update; a port sample scans min(PORT_BITS, CHANNELS) bits, one memory
// update per newly set bit; a read in range runs the 32-step divider (steps skipped on a zero
// interval or a saturated quotient) and waits in its done state until the output is free.
// Reset: asynchronous; per-entry valid bits make every count and time read as zero.
`default_nettype none
module multichannel_frequency_counter #(
	parameter int CHANNELS  = 32,
	parameter int PORT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   command,
	input  logic [mfc_pkg::CH_IN_W-1:0]   channel,
	input  logic [mfc_pkg::IN_PORT_W-1:0] port_value,
	input  logic [mfc_pkg::TIME_W-1:0]    now_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mfc_pkg::Q_W-1:0]       freq_millihertz,
	output logic [1:0]                   read_status
);
	import mfc_pkg::*;

	localparam int CH_W      = $clog2(CHANNELS);
	localparam int SCAN_BITS = (PORT_BITS < CHANNELS) ? PORT_BITS : CHANNELS;
	localparam int BIT_W     = (SCAN_BITS > 1) ? $clog2(SCAN_BITS) : 1;
	localparam int EXT_W     = (PORT_BITS > IN_PORT_W) ? PORT_BITS : IN_PORT_W;
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(SCAN_BITS - 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PSCAN = 8'b0000_0010,
		S_PINC  = 8'b0000_0100,
		S_EDGE  = 8'b0000_1000,
		S_READ  = 8'b0001_0000,
		S_START = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic [PORT_BITS-1:0] last_q;

	logic [CNT_W-1:0]    cnt_mem [CHANNELS];
	logic [TIME_W-1:0]   tim_mem [CHANNELS];
	logic [CHANNELS-1:0] cnt_vld_q;
	logic [CHANNELS-1:0] tim_vld_q;
	logic [CNT_W-1:0]    cnt_rd_q;
	logic                cnt_rdv_q;
	logic [TIME_W-1:0]   tim_rd_q;
	logic                tim_rdv_q;

	logic [SCAN_BITS-1:0] scan_q;
	logic [BIT_W-1:0]    bit_q;
	logic [CH_W-1:0]     ch_q;
	logic [TIME_W-1:0]   now_q;
	logic [NUM_W-1:0]    num_q;
	logic [TIME_W-1:0]   den_q;
	logic [Q_W-1:0]      res_freq_q;
	status_t             res_st_q;
	logic [Q_W-1:0]      freq_q;
	status_t             st_q;

	logic                accept;
	cmd_t                cmd;
	logic                ch_ok;
	logic [CH_W-1:0]     ch_addr;
	logic [CH_W-1:0]     bit_addr;
	logic                bit_hit;
	logic                out_free;
	logic [EXT_W-1:0]    port_ext;
	logic [PORT_BITS-1:0] raw;
	logic [PORT_BITS-1:0] fresh;
	logic [CNT_W-1:0]    cnt_val;
	logic [TIME_W-1:0]   tim_val;

	logic                cnt_re;
	logic [CH_W-1:0]     cnt_raddr;
	logic                cnt_we;
	logic [CH_W-1:0]     cnt_waddr;
	logic [CNT_W-1:0]    cnt_wdata;
	logic                tim_re;
	logic                tim_we;
	logic [CH_W-1:0]     tim_waddr;
	logic [TIME_W-1:0]   tim_wdata;

	logic                div_start;
	logic                div_done;
	logic [Q_W-1:0]      div_quot;
	status_t             div_status;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign cmd      = cmd_t'(command);
	assign ch_ok    = (32'(channel) < 32'(CHANNELS));
	assign ch_addr  = CH_W'(channel);
	assign bit_addr = CH_W'(bit_q);
	assign bit_hit  = scan_q[bit_q];
	assign out_free = ~out_valid_q | out_ready;

	// Input bits above the port word read as zero and therefore invert to one.
	assign port_ext = EXT_W'(port_value);
	assign raw      = ~port_ext[PORT_BITS-1:0];
	assign fresh    = raw & ~last_q;

	assign cnt_val = cnt_rdv_q ? cnt_rd_q : '0;
	assign tim_val = tim_rdv_q ? tim_rd_q : '0;

	assign cnt_re    = (accept && ch_ok && (cmd == CMD_EDGE || cmd == CMD_READ)) ||
	                   (state_q == S_PSCAN && bit_hit);
	assign cnt_raddr = (state_q == S_PSCAN) ? bit_addr : ch_addr;
	assign tim_re    = accept && ch_ok && (cmd == CMD_READ);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = ch_q;
		cnt_wdata = '0;
		tim_we    = 1'b0;
		tim_waddr = ch_q;
		tim_wdata = now_q;
		case (state_q)
			S_IDLE: begin
				cnt_we    = accept && ch_ok && (cmd == CMD_CLEAR);
				cnt_waddr = ch_addr;
				tim_we    = cnt_we;
				tim_waddr = ch_addr;
				tim_wdata = now_us;
			end
			S_PINC: begin
				cnt_we    = 1'b1;
				cnt_waddr = bit_addr;
				cnt_wdata = cnt_val + 1'b1;
			end
			S_EDGE: begin
				cnt_we    = 1'b1;
				cnt_wdata = cnt_val + 1'b1;
			end
			S_READ: begin
				cnt_we = 1'b1;
				tim_we = 1'b1;
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q  <= cnt_mem[cnt_raddr];
			cnt_rdv_q <= cnt_vld_q[cnt_raddr];
		end
		if (tim_we) begin
			tim_mem[tim_waddr] <= tim_wdata;
		end
		if (tim_re) begin
			tim_rd_q  <= tim_mem[ch_addr];
			tim_rdv_q <= tim_vld_q[ch_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			tim_vld_q <= '0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
			if (tim_we) begin
				tim_vld_q[tim_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PORT: begin
								last_q  <= raw;
								state_q <= S_PSCAN;
							end
							CMD_EDGE: begin
								if (ch_ok) begin
									state_q <= S_EDGE;
								end
							end
							CMD_READ: begin
								state_q <= ch_ok ? S_READ : S_DONE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PSCAN: begin
					if (bit_hit) begin
						state_q <= S_PINC;
					end else if (bit_q == BIT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_PINC: begin
					state_q <= (bit_q == BIT_LAST) ? S_IDLE : S_PSCAN;
				end
				S_EDGE: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q       <= ch_addr;
			now_q      <= now_us;
			scan_q     <= fresh[SCAN_BITS-1:0];
			bit_q      <= '0;
			res_freq_q <= '0;
			res_st_q   <= ST_OK;
		end
		if ((state_q == S_PSCAN && !bit_hit && bit_q != BIT_LAST) ||
		    (state_q == S_PINC && bit_q != BIT_LAST)) begin
			bit_q <= bit_q + 1'b1;
		end
		if (state_q == S_READ) begin
			num_q <= NUM_W'(cnt_val) * NUM_W'(SCALE);
			den_q <= now_q - tim_val;
		end
		if (state_q == S_DIV && div_done) begin
			res_freq_q <= div_quot;
			res_st_q   <= div_status;
		end
		if (state_q == S_DONE && out_free) begin
			freq_q <= res_freq_q;
			st_q   <= res_st_q;
		end
	end

	assign div_start = (state_q == S_START);

	mfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot),
		.status (div_status)
	);

	assign out_valid       = out_valid_q;
	assign freq_millihertz = freq_q;
	assign read_status     = st_q;

	// The sequencer never reads and writes the count memory in the same cycle.
	a_cnt_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(cnt_we && cnt_re))
		else $error("count memory read and written in one cycle");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_status == ST_ZERO) |-> (freq_millihertz == '0))
		else $error("zero interval item carries a nonzero frequency");

	a_sat_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_status == ST_SAT) |-> (freq_millihertz == '1))
		else $error("saturated item is not all ones");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multichannel_frequency_counter: a directed table, then random
// commands, each reading checked against its table row or a behavioral model of the counters
// and times. Depends on mfc_pkg and the counter itself.
module tb;
	import mfc_pkg::*;

	typedef struct packed {
		logic [Q_W-1:0] freq;
		status_t        status;
	} reading_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [CH_IN_W-1:0]   ch;
		logic [IN_PORT_W-1:0] port;
		logic [TIME_W-1:0]    now;
		bit                   fixed;
		reading_t             want;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           command = CMD_PORT;
	logic [CH_IN_W-1:0]   channel = '0;
	logic [IN_PORT_W-1:0] port_value = '0;
	logic [TIME_W-1:0]    now_us = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [Q_W-1:0]       freq_millihertz;
	logic [1:0]           read_status;

	// Model state: per-channel edge tallies and time of last read or clear.
	logic [CNT_W-1:0]     tally [32];
	logic [TIME_W-1:0]    mark_us [32];
	logic [IN_PORT_W-1:0] prev_level = '0;
	logic [TIME_W-1:0]    clock_us = '0;

	reading_t owed_readings [$];
	int       mismatches = 0;
	bit       src_calm = 1'b0;
	bit       snk_calm = 1'b0;

	multichannel_frequency_counter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.channel(channel),
		.port_value(port_value),
		.now_us(now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.freq_millihertz(freq_millihertz),
		.read_status(read_status)
	);

	always #4 clk = ~clk;

	// Updates the model for one accepted command; returns 1 when a reading is due.
	// The channel field is five bits wide, so every channel is in range here.
	function automatic bit predict_frequency(input cmd_t cmd, input logic [CH_IN_W-1:0] ch,
			input logic [IN_PORT_W-1:0] port, input logic [TIME_W-1:0] now,
			output reading_t r);
		logic [IN_PORT_W-1:0] level;
		logic [IN_PORT_W-1:0] rise;
		logic [TIME_W-1:0]    span;
		logic [63:0]          q;
		int                   i;
		r = '0;
		r.status = ST_OK;
		case (cmd)
		CMD_PORT: begin
			level = ~port;
			rise = level & ~prev_level;
			for (i = 0; i < IN_PORT_W; i++)
				if (rise[i])
					tally[i] = tally[i] + 1'b1;
			prev_level = level;
		end
		CMD_EDGE: begin
			tally[ch] = tally[ch] + 1'b1;
		end
		CMD_CLEAR: begin
			tally[ch] = '0;
			mark_us[ch] = now;
		end
		CMD_READ: begin
			// The interval wraps with the 48-bit time.
			span = now - mark_us[ch];
			q = 64'(tally[ch]) * 64'd1_000_000_000;
			tally[ch] = '0;
			mark_us[ch] = now;
			if (span == '0) begin
				r.status = ST_ZERO;
			end else begin
				q = q / 64'(span);
				if (q > 64'h0000_0000_FFFF_FFFF) begin
					r.freq = '1;
					r.status = ST_SAT;
				end else begin
					r.freq = q[Q_W-1:0];
				end
			end
		end
		endcase
		return cmd == CMD_READ;
	endfunction

	function automatic step_t table_row(input cmd_t cmd, input int ch,
			input logic [IN_PORT_W-1:0] port, input logic [TIME_W-1:0] now,
			input bit fixed, input logic [Q_W-1:0] freq, input status_t status);
		step_t s;
		s.cmd = cmd;
		s.ch = CH_IN_W'(ch);
		s.port = port;
		s.now = now;
		s.fixed = fixed;
		s.want.freq = freq;
		s.want.status = status;
		return s;
	endfunction

	// Time mostly moves forward in small steps; sometimes it stalls, creeps or jumps.
	function automatic step_t random_step();
		step_t s;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			s.cmd = CMD_PORT;
		else if (pick < 70)
			s.cmd = CMD_EDGE;
		else if (pick < 85)
			s.cmd = CMD_READ;
		else
			s.cmd = CMD_CLEAR;
		s.ch = CH_IN_W'($urandom_range(0, 31));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			s.port = '0;
		else if (pick == 1)
			s.port = '1;
		else
			s.port = IN_PORT_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 65)
			clock_us = clock_us + TIME_W'($urandom_range(1, 4000));
		else if (pick < 80)
			clock_us = clock_us + TIME_W'($urandom_range(1, 3));
		else if (pick >= 92)
			clock_us = TIME_W'({$urandom, $urandom});
		s.now = clock_us;
		s.fixed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	task automatic issue_command(input step_t s);
		int       gap;
		reading_t got;
		gap = src_calm ? 0 : $urandom_range(0, 17);
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= s.cmd;
		channel    <= s.ch;
		port_value <= s.port;
		now_us     <= s.now;
		do @(posedge clk); while (!in_ready);
		if (predict_frequency(s.cmd, s.ch, s.port, s.now, got))
			owed_readings.push_back(s.fixed ? s.want : got);
	endtask

	initial begin : stimulus
		step_t plan [$];
		int    k;
		for (k = 0; k < 32; k++) begin
			tally[k] = '0;
			mark_us[k] = '0;
		end
		// After reset every time is zero: a read at time zero sees no interval.
		plan.push_back(table_row(CMD_READ, 0, 16'h0000, 48'd0, 1, 32'd0, ST_ZERO));
		plan.push_back(table_row(CMD_READ, 5, 16'h0000, 48'd1000, 1, 32'd0, ST_OK));
		// Port toggles: all inactive, all active, then alternating bit patterns.
		plan.push_back(table_row(CMD_PORT, 0, 16'hFFFF, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'h5555, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'hFFFF, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'h5555, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_PORT, 0, 16'hAAAA, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_EDGE, 31, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_EDGE, 31, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_READ, 31, 16'h0000, 48'd1, 1, 32'd2_000_000_000, ST_OK));
		// Five more counts on channel 31 over one microsecond saturate the quotient.
		for (k = 0; k < 5; k++)
			plan.push_back(table_row(CMD_EDGE, 31, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_READ, 31, 16'h0000, 48'd2, 1, 32'hFFFF_FFFF, ST_SAT));
		// Clear at the top of the time range, then read after the wrap.
		plan.push_back(table_row(CMD_CLEAR, 7, 16'h0000, '1, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_EDGE, 7, 16'h0000, 48'd0, 0, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_READ, 7, 16'h0000, 48'd0, 1, 32'd1_000_000_000, ST_OK));
		plan.push_back(table_row(CMD_READ, 7, 16'h0000, 48'd0, 1, 32'd0, ST_ZERO));
		plan.push_back(table_row(CMD_READ, 3, 16'h0000, '1, 1, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_READ, 16, 16'h0000, '1, 1, 32'd0, ST_OK));
		plan.push_back(table_row(CMD_READ, 10, 16'h0000, 48'd500, 1, 32'd4_000_000, ST_OK));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < plan.size(); k++)
			issue_command(plan[k]);
		for (k = 0; k < 1900; k++)
			issue_command(random_step());
		in_valid <= 1'b0;
		while (owed_readings.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Result side: either ready ahead of the item, or hold it off for a while once it shows.
	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = snk_calm ? 0 : $urandom_range(0, 17);
			if ($urandom_range(0, 29) == 0)
				snk_calm = !snk_calm;
			if (stall == 0) begin
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
			end else begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall - 1) @(posedge clk);
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_reading
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_readings.size() == 0) begin
				$display("%0t: reading with none expected: freq %0d status %0d",
					$time, freq_millihertz, read_status);
				mismatches++;
			end else begin
				want = owed_readings.pop_front();
				if (freq_millihertz !== want.freq) begin
					$display("%0t: freq_millihertz expected %0d, got %0d",
						$time, want.freq, freq_millihertz);
					mismatches++;
				end
				if (read_status !== want.status) begin
					$display("%0t: read_status expected %0d, got %0d",
						$time, want.status, read_status);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
